// File: rtl/ssa_pkg.sv
// Shared types and constants of the subpixel splat accumulator.
`default_nettype none

package ssa_pkg;

   localparam int unsigned CHAN_W = 8;
   localparam logic [CHAN_W-1:0] CHANNEL_MAX = 8'hFF;
   localparam logic [1:0] LAST_NEIGHBOR = 2'd3;

   typedef struct packed {
      logic [15:0]       pos_x;
      logic [15:0]       pos_y;
      logic [CHAN_W-1:0] color_red;
      logic [CHAN_W-1:0] color_green;
      logic [CHAN_W-1:0] color_blue;
   } req_type;

   typedef struct packed {
      logic [7:0]        pixel_index;
      logic              in_range;
      logic [CHAN_W-1:0] new_red;
      logic [CHAN_W-1:0] new_green;
      logic [CHAN_W-1:0] new_blue;
      logic              last_of_splat;
   } rsp_type;

   // One neighbor update, as handed from the front end to the store pipeline.
   typedef struct packed {
      logic [7:0]        pixel_index;
      logic              in_range;
      logic [CHAN_W-1:0] weight;
      logic [CHAN_W-1:0] color_red;
      logic [CHAN_W-1:0] color_green;
      logic [CHAN_W-1:0] color_blue;
      logic              last_of_splat;
   } op_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

endpackage

`default_nettype wire

// File: rtl/ssa_front.sv
// Front end: accepts splats and expands each into four weighted neighbor updates.
`default_nettype none

module ssa_front #(
   parameter int unsigned PIXEL_COUNT = 256,
   parameter int unsigned ROW_STRIDE  = 16,
   parameter int unsigned ADDR_W      = 8
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_ready,
   input  wire ssa_pkg::req_type req_payload,
   input  wire logic            clearing,
   input  wire logic            queue_full,
   output      logic            op_push,
   output      ssa_pkg::op_type op_data,
   output      logic [ADDR_W-1:0] op_addr
);
   import ssa_pkg::*;

   // Column and row reach 256 after the +1 step; the sum must not wrap.
   localparam int unsigned FULL_W = 9 + $clog2(ROW_STRIDE) + 1;

   logic        busy_ff, busy_in;
   logic [1:0]  k_ff, k_in;
   req_type     splat_ff, splat_in;

   logic [7:0]        frac_x, frac_y, wa, wb;
   logic [15:0]       wsum;
   logic [8:0]        col, row;
   logic [FULL_W-1:0] full_addr;
   logic              addr_ok;
   logic              accept, last_k;

   assign last_k    = (k_ff == LAST_NEIGHBOR);
   assign op_push   = busy_ff && !queue_full;
   assign req_ready = !clearing && (!busy_ff || (!queue_full && last_k));
   assign accept    = req_valid && req_ready;

   always_comb begin
      frac_x = splat_ff.pos_x[7:0];
      frac_y = splat_ff.pos_y[7:0];
      wa     = k_ff[0] ? frac_x : (CHANNEL_MAX - frac_x);
      wb     = k_ff[1] ? frac_y : (CHANNEL_MAX - frac_y);
      wsum   = 16'(wa) * 16'(wb) + 16'(wa) + 16'(wb);

      col       = {1'b0, splat_ff.pos_x[15:8]} + 9'(k_ff[0]);
      row       = {1'b0, splat_ff.pos_y[15:8]} + 9'(k_ff[1]);
      full_addr = FULL_W'(col) + FULL_W'(row) * FULL_W'(ROW_STRIDE);
      addr_ok   = 32'(full_addr) < 32'(PIXEL_COUNT);

      op_data.pixel_index   = addr_ok ? full_addr[7:0] : 8'd0;
      op_data.in_range      = addr_ok;
      op_data.weight        = wsum[15:8];
      op_data.color_red     = splat_ff.color_red;
      op_data.color_green   = splat_ff.color_green;
      op_data.color_blue    = splat_ff.color_blue;
      op_data.last_of_splat = last_k;
      op_addr               = full_addr[ADDR_W-1:0];
   end

   always_comb begin
      busy_in  = busy_ff;
      k_in     = k_ff;
      splat_in = splat_ff;
      if (op_push) begin
         k_in = k_ff + 2'd1;
         if (last_k) begin
            busy_in = 1'b0;
         end
      end
      if (accept) begin
         busy_in  = 1'b1;
         k_in     = '0;
         splat_in = req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         k_ff    <= '0;
      end else begin
         busy_ff <= busy_in;
         k_ff    <= k_in;
      end
      splat_ff <= splat_in;
   end

endmodule

`default_nettype wire

// File: rtl/ssa_queue.sv
// Small register queue that decouples the front end from the store pipeline.
`default_nettype none

module ssa_queue #(
   parameter int unsigned DATA_W = 8,
   parameter int unsigned DEPTH  = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   output      logic              full,
   input  wire logic              pop,
   output      logic              not_empty,
   output      logic [DATA_W-1:0] head_data
);
   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: rtl/ssa_back.sv
// Store pipeline: frame store read, weighted saturating add, write back and result register.
`default_nettype none

module ssa_back #(
   parameter int unsigned PIXEL_COUNT = 256,
   parameter int unsigned ADDR_W      = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              op_valid,
   output      logic              op_pop,
   input  wire ssa_pkg::op_type   op_data,
   input  wire logic [ADDR_W-1:0] op_addr,
   output      logic              clearing,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      ssa_pkg::rsp_type  rsp_payload
);
   import ssa_pkg::*;

   pixel_type frame_store_ff [PIXEL_COUNT];

   logic              clr_ff, clr_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;

   logic              s2_valid_ff, s2_valid_in;
   op_type            s2_op_ff;
   logic [ADDR_W-1:0] s2_addr_ff;
   pixel_type         rd_data_ff;

   logic              fwd_valid_ff, fwd_valid_in;
   logic [ADDR_W-1:0] fwd_addr_ff;
   pixel_type         fwd_data_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              rsp_advance, s2_fire, store_we;
   pixel_type         base, new_pixel;

   function automatic logic [CHAN_W-1:0] sat_add(input logic [CHAN_W-1:0] stored,
                                                 input logic [CHAN_W-1:0] color,
                                                 input logic [CHAN_W-1:0] weight);
      logic [2*CHAN_W-1:0] prod;
      logic [CHAN_W:0]     sum;
      prod = (2*CHAN_W)'(color) * (2*CHAN_W)'(weight);
      sum  = {1'b0, stored} + {1'b0, prod[2*CHAN_W-1:CHAN_W]};
      return sum[CHAN_W] ? CHANNEL_MAX : sum[CHAN_W-1:0];
   endfunction

   assign clearing    = clr_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign rsp_advance = !rsp_valid_ff || rsp_ready;
   assign s2_fire     = s2_valid_ff && rsp_advance;
   assign op_pop      = op_valid && !clr_ff && (!s2_valid_ff || s2_fire);
   assign store_we    = s2_fire && s2_op_ff.in_range;

   // The read for the op in stage two happened at the same edge as the previous
   // write, so it saw the old pixel; take the written value when addresses match.
   always_comb begin
      base = (fwd_valid_ff && (fwd_addr_ff == s2_addr_ff)) ? fwd_data_ff : rd_data_ff;
      new_pixel.red   = sat_add(base.red,   s2_op_ff.color_red,   s2_op_ff.weight);
      new_pixel.green = sat_add(base.green, s2_op_ff.color_green, s2_op_ff.weight);
      new_pixel.blue  = sat_add(base.blue,  s2_op_ff.color_blue,  s2_op_ff.weight);
   end

   always_comb begin
      clr_in     = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clr_ff) begin
         clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
         if (clr_cnt_ff == ADDR_W'(PIXEL_COUNT - 1)) begin
            clr_in = 1'b0;
         end
      end

      s2_valid_in = s2_valid_ff;
      if (op_pop) begin
         s2_valid_in = 1'b1;
      end else if (s2_fire) begin
         s2_valid_in = 1'b0;
      end

      fwd_valid_in = op_pop ? store_we : fwd_valid_ff;

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (s2_fire) begin
         rsp_valid_in         = 1'b1;
         rsp_in.pixel_index   = s2_op_ff.pixel_index;
         rsp_in.in_range      = s2_op_ff.in_range;
         rsp_in.new_red       = s2_op_ff.in_range ? new_pixel.red   : '0;
         rsp_in.new_green     = s2_op_ff.in_range ? new_pixel.green : '0;
         rsp_in.new_blue      = s2_op_ff.in_range ? new_pixel.blue  : '0;
         rsp_in.last_of_splat = s2_op_ff.last_of_splat;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= 1'b1;
         clr_cnt_ff   <= '0;
         s2_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         clr_cnt_ff   <= clr_cnt_in;
         s2_valid_ff  <= s2_valid_in;
         fwd_valid_ff <= fwd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
      if (op_pop) begin
         s2_op_ff    <= op_data;
         s2_addr_ff  <= op_addr;
         fwd_addr_ff <= s2_addr_ff;
         fwd_data_ff <= new_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_ff) begin
         frame_store_ff[clr_cnt_ff] <= '0;
      end else if (store_we) begin
         frame_store_ff[s2_addr_ff] <= new_pixel;
      end
      if (op_pop) begin
         rd_data_ff <= frame_store_ff[op_addr];
      end
   end

   a_no_pop_while_clearing : assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !op_pop)
      else $error("store pipeline took an update during the clearing pass");

   a_no_result_while_clearing : assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !rsp_valid_ff && !s2_valid_ff)
      else $error("result present during the clearing pass");

   a_out_of_range_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.in_range |->
         rsp_ff.pixel_index == 8'd0 && rsp_ff.new_red == '0 &&
         rsp_ff.new_green == '0 && rsp_ff.new_blue == '0)
      else $error("out-of-range result carries nonzero fields");

   a_store_write_only_on_fire : assert property (@(posedge clock) disable iff (reset)
      store_we |=> rsp_valid_ff)
      else $error("frame store written without a result being produced");

endmodule

`default_nettype wire

// File: rtl/subpixel_splat_accumulator_core.sv
// Top level of the subpixel splat accumulator: front end, op queue and store pipeline.
//
// Usage: each transaction on the req_ channel is one splat, an 8.8 fixed-point
// position and an RGB color. The block spreads it over the four neighboring
// pixels with bilinear weights, adds the weighted color with saturation into an
// internal frame store of PIXEL_COUNT pixels, and returns four transactions on
// the rsp_ channel, one per neighbor in the order (col,row), (col+1,row),
// (col,row+1), (col+1,row+1). The fourth one has last_of_splat set.
// Throughput: the front end issues one neighbor per cycle while the queue is not
// full, and the frame store does one read-modify-write per cycle while results are
// taken. Each update passes the splat register, the queue, the stage-two register
// and the output register in that order; a new splat is taken as the last neighbor issues.
// Reset: a synchronous reset starts a clearing pass that zeroes the frame store,
// one pixel per cycle, over all PIXEL_COUNT pixels; req_ready stays low until it ends.
// Stalls: results wait in an output register; a four-entry queue between the
// front end and the store pipeline keeps the front end taking splats until it
// fills, after which req_ready drops until rsp_ready returns.
`default_nettype none

module subpixel_splat_accumulator_core #(
   parameter int unsigned PIXEL_COUNT = 256,
   parameter int unsigned ROW_STRIDE  = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire ssa_pkg::req_type req_payload,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      ssa_pkg::rsp_type rsp_payload
);
   import ssa_pkg::*;

   // Address width of the frame store.
   localparam int unsigned ADDR_W  = $clog2(PIXEL_COUNT);
   localparam int unsigned Q_DEPTH = 4;
   localparam int unsigned Q_W     = ADDR_W + $bits(op_type);

   logic              clearing;
   logic              q_full, q_not_empty, op_push, op_pop;
   op_type            push_op, head_op;
   logic [ADDR_W-1:0] push_addr, head_addr;
   logic [Q_W-1:0]    q_head;

   // The front end expands each splat into four neighbor updates.
   ssa_front #(
      .PIXEL_COUNT(PIXEL_COUNT),
      .ROW_STRIDE (ROW_STRIDE),
      .ADDR_W     (ADDR_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .clearing   (clearing),
      .queue_full (q_full),
      .op_push    (op_push),
      .op_data    (push_op),
      .op_addr    (push_addr)
   );

   // The queue carries the store address alongside the update itself.
   ssa_queue #(
      .DATA_W(Q_W),
      .DEPTH (Q_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (op_push),
      .push_data({push_addr, push_op}),
      .full     (q_full),
      .pop      (op_pop),
      .not_empty(q_not_empty),
      .head_data(q_head)
   );

   assign head_op   = q_head[$bits(op_type)-1:0];
   assign head_addr = q_head[Q_W-1:$bits(op_type)];

   // The store pipeline owns the frame store, its clearing pass and the result register.
   ssa_back #(
      .PIXEL_COUNT(PIXEL_COUNT),
      .ADDR_W     (ADDR_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .op_valid   (q_not_empty),
      .op_pop     (op_pop),
      .op_data    (head_op),
      .op_addr    (head_addr),
      .clearing   (clearing),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule

`default_nettype wire
